### design/lcsrk_pkg.sv
`default_nettype none

package lcsrk_pkg;

  // converter width default, handed to the top level
  localparam int unsigned ADC_BITS_DEF = 24;

  // fixed field widths
  localparam int unsigned OFFSET_W  = 24;
  localparam int unsigned WEIGHT_W  = 32;
  localparam int unsigned SCALE_W   = 32;
  localparam int unsigned LIMIT_W   = 31;
  localparam int unsigned NOISE_W   = 32;
  localparam int unsigned GAIN_W    = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned CNT_W     = 5;

  // one multiplier bit per cycle
  localparam int unsigned SCALE_STEPS = SCALE_W;
  localparam int unsigned GAIN_STEPS  = GAIN_W;

  // gain of one in Q1.16
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

  // reset values of the registers
  localparam logic [OFFSET_W-1:0] ZERO_OFFSET_RST   = 24'd0;
  localparam logic [SCALE_W-1:0]  SCALE_RST         = 32'd65536;
  localparam logic [LIMIT_W-1:0]  LIMIT_NORMAL_RST  = 31'd444;
  localparam logic [LIMIT_W-1:0]  LIMIT_RAISED_RST  = 31'd888;
  localparam logic [NOISE_W-1:0]  MEAS_NOISE_RST    = 32'd0;
  localparam logic [NOISE_W-1:0]  PROC_NOISE_RST    = 32'd43647;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 32'h7FFF_FFFF;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_OFFSET  = 3'd0,
    CFG_SCALE        = 3'd1,
    CFG_LIMIT_NORMAL = 3'd2,
    CFG_LIMIT_RAISED = 3'd3,
    CFG_MEAS_NOISE   = 3'd4,
    CFG_PROC_NOISE   = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_SAT,
    ST_CHECK,
    ST_DELTA,
    ST_KMUL,
    ST_SUM,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

### design/load_cell_spike_reject_kalman_top.sv
`default_nettype none

// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o tdata: adc_sample
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i tdata: filtered, checked; tuser: exceeded
// cfg       in   cfg_valid_i/cfg_ready_o         cfg_index_i, cfg_data_i
//
// a new word is accepted only after the previous one has passed through all steps
// and its result has been written to the output register; the time is set by the
// bit-serial scale multiplier (gain divider runs beside it) and the bit-serial
// kalman multipliers (one step per gain bit)
// reset clears the registers to their defaults and the filter state to zero
// a waiting result sits in the output register; the block holds in its last step
// only when a new result is ready and the previous one has not yet been taken

module load_cell_spike_reject_kalman_top #(
  parameter int unsigned ADC_BITS = lcsrk_pkg::ADC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // input stream
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [ADC_BITS-1:0] adc_sample, rest zero
  input  wire logic [((ADC_BITS+7)/8)*8-1:0]    s_axis_tdata_i,
  // result stream
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // [31:0] filtered_weight, [63:32] checked_weight
  output logic [2*lcsrk_pkg::WEIGHT_W-1:0]      m_axis_tdata_o,
  // [0] limit_exceeded
  output logic                                  m_axis_tuser_o,
  // register writes
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [lcsrk_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [lcsrk_pkg::CFG_DAT_W-1:0]  cfg_data_i
);

  localparam int unsigned WW  = lcsrk_pkg::WEIGHT_W;
  localparam int unsigned GW  = lcsrk_pkg::GAIN_W;
  localparam int unsigned NW  = lcsrk_pkg::NOISE_W;
  localparam int unsigned SW  = lcsrk_pkg::SCALE_W;
  localparam int unsigned OW  = lcsrk_pkg::OFFSET_W;
  localparam int unsigned LW  = lcsrk_pkg::LIMIT_W;
  localparam int unsigned CW  = lcsrk_pkg::CNT_W;
  // difference of sample and tare, one bit of headroom
  localparam int unsigned DW  = ((ADC_BITS > OW) ? ADC_BITS : OW) + 1;
  // truncated scale product
  localparam int unsigned QW  = DW + 16;
  // jump and innovation width
  localparam int unsigned JW  = WW + 1;
  // kalman accumulator high part, signed
  localparam int unsigned KHW = JW + 1;
  // estimate times 2^16 plus gain product
  localparam int unsigned SUMW = KHW + GW + 1;
  localparam int unsigned EPW  = NW + GW;

  localparam logic [CW-1:0] SCALE_LAST = CW'(lcsrk_pkg::SCALE_STEPS - 1);
  localparam logic [CW-1:0] GAIN_LAST  = CW'(lcsrk_pkg::GAIN_STEPS - 1);

  // ---------------------------------------------------------------------------
  // register file
  // ---------------------------------------------------------------------------
  logic [OW-1:0] zero_offset_q;
  logic [SW-1:0] scale_q;
  logic [LW-1:0] limit_normal_q;
  logic [LW-1:0] limit_raised_q;
  logic [NW-1:0] meas_noise_q;
  logic [NW-1:0] proc_noise_q;

  logic cfg_fire;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_offset_q  <= lcsrk_pkg::ZERO_OFFSET_RST;
      scale_q        <= lcsrk_pkg::SCALE_RST;
      limit_normal_q <= lcsrk_pkg::LIMIT_NORMAL_RST;
      limit_raised_q <= lcsrk_pkg::LIMIT_RAISED_RST;
      meas_noise_q   <= lcsrk_pkg::MEAS_NOISE_RST;
      proc_noise_q   <= lcsrk_pkg::PROC_NOISE_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        lcsrk_pkg::CFG_ZERO_OFFSET:  zero_offset_q  <= cfg_data_i[OW-1:0];
        lcsrk_pkg::CFG_SCALE:        scale_q        <= cfg_data_i[SW-1:0];
        lcsrk_pkg::CFG_LIMIT_NORMAL: limit_normal_q <= cfg_data_i[LW-1:0];
        lcsrk_pkg::CFG_LIMIT_RAISED: limit_raised_q <= cfg_data_i[LW-1:0];
        lcsrk_pkg::CFG_MEAS_NOISE:   meas_noise_q   <= cfg_data_i[NW-1:0];
        lcsrk_pkg::CFG_PROC_NOISE:   proc_noise_q   <= cfg_data_i[NW-1:0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  lcsrk_pkg::state_e state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              in_fire;
  logic              done_fire;
  logic              m_valid_q, m_valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lcsrk_pkg::ST_IDLE:  if (in_fire) state_d = lcsrk_pkg::ST_PREP;
      lcsrk_pkg::ST_PREP:  state_d = lcsrk_pkg::ST_MUL;
      lcsrk_pkg::ST_MUL:   if (cnt_q == SCALE_LAST) state_d = lcsrk_pkg::ST_SAT;
      lcsrk_pkg::ST_SAT:   state_d = lcsrk_pkg::ST_CHECK;
      lcsrk_pkg::ST_CHECK: state_d = lcsrk_pkg::ST_DELTA;
      lcsrk_pkg::ST_DELTA: state_d = lcsrk_pkg::ST_KMUL;
      lcsrk_pkg::ST_KMUL:  if (cnt_q == GAIN_LAST) state_d = lcsrk_pkg::ST_SUM;
      lcsrk_pkg::ST_SUM:   state_d = lcsrk_pkg::ST_DONE;
      lcsrk_pkg::ST_DONE:  if (done_fire) state_d = lcsrk_pkg::ST_IDLE;
      default:             state_d = lcsrk_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    done_fire       = 1'b0;
    cnt_d           = '0;
    unique case (state_q) inside
      lcsrk_pkg::ST_IDLE: s_axis_tready_o = 1'b1;
      lcsrk_pkg::ST_MUL,
      lcsrk_pkg::ST_KMUL: cnt_d = cnt_q + 1'b1;
      lcsrk_pkg::ST_DONE: done_fire = !m_valid_q || m_axis_tready_i;
      default: ;
    endcase
  end

  assign in_fire = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready_i) m_valid_d = 1'b0;
    if (done_fire) m_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lcsrk_pkg::ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  // ---------------------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------------------
  logic [ADC_BITS-1:0] adc_sample;
  logic [DW-1:0]       adc_ext, offset_ext;
  assign adc_sample = s_axis_tdata_i[ADC_BITS-1:0];
  assign adc_ext    = {{(DW-ADC_BITS){adc_sample[ADC_BITS-1]}}, adc_sample};
  assign offset_ext = {{(DW-OW){zero_offset_q[OW-1]}}, zero_offset_q};

  // working registers, no reset needed
  logic [DW-1:0]   diff_q;
  logic [DW-1:0]   mag_q;
  logic            neg_q;
  logic [DW-1:0]   mhi_q;        // scale product, high part
  logic [SW-1:0]   mlo_q;        // scale bits shifting out, product bits shifting in
  logic [NW+1:0]   rem_q;        // divider remainder
  logic [NW:0]     den_q;        // meas noise plus error
  logic [GW-1:0]   quo_q;
  logic [GW-1:0]   gain_q;
  logic [WW-1:0]   z_q;          // scaled, saturated
  logic [WW-1:0]   zc_q;         // after spike check
  logic            rej_q;
  logic [JW-1:0]   delta_q;
  logic [KHW-1:0]  khi_q;        // gain times innovation, signed
  logic [GW-1:0]   klo_q;
  logic [NW-1:0]   ehi_q;        // (1 - gain) times error
  logic [GW-1:0]   elo_q;
  logic [SUMW-1:0] sum_q;
  logic [NW+1:0]   ne_q;

  // filter state
  logic [WW-1:0]   prev_q;
  logic            spike_q;
  logic [WW-1:0]   est_q;
  logic [NW-1:0]   err_q;

  // output register
  logic [WW-1:0]   out_filt_q;
  logic [WW-1:0]   out_chk_q;
  logic            out_exc_q;

  // scale multiplier step
  logic [DW:0]     msum;
  assign msum = {1'b0, mhi_q} + (mlo_q[0] ? {1'b0, mag_q} : '0);

  // gain divider step, first step without the shift
  logic [NW+1:0]   dtrial;
  logic            dge;
  assign dtrial = (cnt_q == '0) ? rem_q : {rem_q[NW:0], 1'b0};
  assign dge    = dtrial >= {1'b0, den_q};

  // saturation of the truncated scale product
  logic [QW-1:0]   qprod;
  logic            qsat;
  logic [WW-1:0]   zsat;
  assign qprod = {mhi_q, mlo_q[SW-1:16]};
  assign qsat  = |qprod[QW-1:WW-1];
  always_comb begin
    if (qsat)       zsat = neg_q ? lcsrk_pkg::WEIGHT_MIN : lcsrk_pkg::WEIGHT_MAX;
    else if (neg_q) zsat = ~qprod[WW-1:0] + 1'b1;
    else            zsat = qprod[WW-1:0];
  end

  // upward jump against the active limit
  logic [JW-1:0]   jump;
  logic [LW-1:0]   limit_act;
  logic            rej;
  assign jump      = {z_q[WW-1], z_q} - {prev_q[WW-1], prev_q};
  assign limit_act = spike_q ? limit_raised_q : limit_normal_q;
  assign rej       = $signed(jump) > $signed({{(JW-LW){1'b0}}, limit_act});

  // kalman multiplier steps
  logic [KHW:0]    ksum;
  logic [NW:0]     esum;
  assign ksum = {khi_q[KHW-1], khi_q} + (klo_q[0] ? {{2{delta_q[JW-1]}}, delta_q} : '0);
  assign esum = {1'b0, ehi_q} + (elo_q[0] ? {1'b0, err_q} : '0);

  // estimate, truncated toward zero, then clamped
  logic [SUMW-1:0]    sum_adj;
  logic [SUMW-17:0]   est_full;
  logic [WW-1:0]      est_new;
  logic [EPW-1:0]     eprod;
  logic [NW-1:0]      err_new;
  assign sum_adj  = sum_q + (sum_q[SUMW-1] ? SUMW'(16'hFFFF) : '0);
  assign est_full = sum_adj[SUMW-1:16];
  always_comb begin
    if (est_full[SUMW-17:WW-1] != '0 && est_full[SUMW-17:WW-1] != '1)
      est_new = est_full[SUMW-17] ? lcsrk_pkg::WEIGHT_MIN : lcsrk_pkg::WEIGHT_MAX;
    else
      est_new = est_full[WW-1:0];
  end
  assign eprod   = {ehi_q, elo_q};
  assign err_new = (ne_q[NW+1:NW] != '0) ? '1 : ne_q[NW-1:0];

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      lcsrk_pkg::ST_IDLE: begin
        if (in_fire) diff_q <= adc_ext - offset_ext;
      end
      lcsrk_pkg::ST_PREP: begin
        neg_q <= diff_q[DW-1];
        mag_q <= diff_q[DW-1] ? (~diff_q + 1'b1) : diff_q;
        mhi_q <= '0;
        mlo_q <= scale_q;
        rem_q <= {2'b00, err_q};
        den_q <= {1'b0, meas_noise_q} + {1'b0, err_q};
      end
      lcsrk_pkg::ST_MUL: begin
        mhi_q <= msum[DW:1];
        mlo_q <= {msum[0], mlo_q[SW-1:1]};
        if (cnt_q <= GAIN_LAST) begin
          rem_q <= dge ? (dtrial - {1'b0, den_q}) : dtrial;
          quo_q <= {quo_q[GW-2:0], dge};
        end
      end
      lcsrk_pkg::ST_SAT: begin
        z_q    <= zsat;
        // both noise terms zero: take the gain as one
        gain_q <= (den_q == '0) ? lcsrk_pkg::GAIN_ONE : quo_q;
      end
      lcsrk_pkg::ST_CHECK: begin
        zc_q  <= rej ? prev_q : z_q;
        rej_q <= rej;
      end
      lcsrk_pkg::ST_DELTA: begin
        delta_q <= {zc_q[WW-1], zc_q} - {est_q[WW-1], est_q};
        khi_q   <= '0;
        klo_q   <= gain_q;
        ehi_q   <= '0;
        elo_q   <= lcsrk_pkg::GAIN_ONE - gain_q;
      end
      lcsrk_pkg::ST_KMUL: begin
        khi_q <= ksum[KHW:1];
        klo_q <= {ksum[0], klo_q[GW-1:1]};
        ehi_q <= esum[NW:1];
        elo_q <= {esum[0], elo_q[GW-1:1]};
      end
      lcsrk_pkg::ST_SUM: begin
        sum_q <= {{(SUMW-WW-16){est_q[WW-1]}}, est_q, 16'h0000}
               + {khi_q[KHW-1], khi_q, klo_q};
        ne_q  <= {1'b0, eprod[EPW-1:16]} + {2'b00, proc_noise_q};
      end
      lcsrk_pkg::ST_DONE: begin
        if (done_fire) begin
          out_filt_q <= est_new;
          out_chk_q  <= zc_q;
          out_exc_q  <= rej_q;
        end
      end
      default: ;
    endcase
  end

  // filter state, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      spike_q <= 1'b0;
      est_q   <= '0;
      err_q   <= '0;
    end else begin
      if (state_q == lcsrk_pkg::ST_CHECK) begin
        prev_q  <= rej ? prev_q : z_q;
        spike_q <= rej;
      end
      if (done_fire) begin
        est_q <= est_new;
        err_q <= err_new;
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {out_chk_q, out_filt_q};
  assign m_axis_tuser_o  = out_exc_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == lcsrk_pkg::ST_PREP)
    else $error("accepted word did not start the sequence");

  a_scale_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcsrk_pkg::ST_MUL && cnt_q == SCALE_LAST) |=> state_q == lcsrk_pkg::ST_SAT)
    else $error("scale multiply did not end after its last bit");

  a_gain_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lcsrk_pkg::ST_DELTA |-> gain_q <= lcsrk_pkg::GAIN_ONE)
    else $error("kalman gain above one");

  a_checked_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lcsrk_pkg::ST_DONE |-> zc_q == prev_q)
    else $error("checked weight differs from the kept previous weight");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready_i && state_q == lcsrk_pkg::ST_DONE)
      |=> state_q == lcsrk_pkg::ST_DONE)
    else $error("result left the sequencer while the output word was held");

endmodule

`default_nettype wire
